// File: sv/i2p_pkg.sv
// shared types, constants and operator table of the infix to postfix converter
package i2p_pkg;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned ENT_W = 5;

  localparam logic [ENT_W-1:0] ENT_LPAREN    = 5'd31;
  localparam logic [ENT_W-1:0] ENT_FUNC_BASE = 5'd16;
  localparam logic [ENT_W-1:0] OP_MAX        = 5'd14;

  typedef enum logic [2:0] {
    REQ_OPERAND  = 3'd0,
    REQ_OPERATOR = 3'd1,
    REQ_FUNCTION = 3'd2,
    REQ_COMMA    = 3'd3,
    REQ_LPAREN   = 3'd4,
    REQ_RPAREN   = 3'd5,
    REQ_END      = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    KIND_OPERAND  = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_FUNCTION = 2'd2,
    KIND_LPAREN   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LPAREN   = 2'd1,
    ERR_RPAREN   = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_CHK,
    ST_RDF,
    ST_CHKF,
    ST_PUSH,
    ST_UNM,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_TOKEN,
    EMIT_TOP,
    EMIT_UNMATCHED,
    EMIT_OVERFLOW
  } emit_e;

  typedef struct packed {
    logic  load_tok;
    emit_e emit;
    logic  pop;
    logic  push;
    logic  flush;
  } cmd_t;

  typedef struct packed {
    req_e tok_type;
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic top_is_op;
    logic top_is_lparen;
    logic top_is_func;
    logic pop_prec;
    logic emit_ok;
    logic flush_ok;
  } sts_t;

  function automatic logic [2:0] op_prec(input logic [3:0] idx);
    logic [2:0] p;
    case (idx) inside
      [4'd0:4'd2]:   p = 3'd1;
      [4'd3:4'd8]:   p = 3'd2;
      [4'd9:4'd10]:  p = 3'd3;
      [4'd11:4'd13]: p = 3'd4;
      default:       p = 3'd5;
    endcase
    return p;
  endfunction

  function automatic logic op_right(input logic [3:0] idx);
    return (idx == 4'd11) || (idx == 4'd14);
  endfunction

endpackage

// File: sv/i2p_ram.sv
// generic single write port ram with registered read
module i2p_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/i2p_ctrl.sv
// sequencing state machine of the infix to postfix converter
module i2p_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  i2p_pkg::sts_t sts_i,
  output i2p_pkg::cmd_t cmd_o
);
  import i2p_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        case (sts_i.tok_type)
          REQ_OPERAND: begin
            if (sts_i.emit_ok) state_d = ST_FIN;
          end
          REQ_OPERATOR:           state_d = sts_i.cnt_zero ? ST_PUSH : ST_RD;
          REQ_FUNCTION, REQ_LPAREN: state_d = ST_PUSH;
          REQ_COMMA, REQ_RPAREN:  state_d = sts_i.cnt_zero ? ST_UNM : ST_RD;
          REQ_END:                state_d = sts_i.cnt_zero ? ST_FIN : ST_RD;
          default:                state_d = ST_FIN;
        endcase
      end
      ST_RD: state_d = ST_CHK;
      ST_CHK: begin
        case (sts_i.tok_type)
          REQ_OPERATOR: begin
            if (sts_i.top_is_op && sts_i.pop_prec) begin
              if (sts_i.emit_ok) state_d = sts_i.cnt_one ? ST_PUSH : ST_RD;
            end else begin
              state_d = ST_PUSH;
            end
          end
          REQ_COMMA, REQ_RPAREN: begin
            if (!sts_i.top_is_lparen) begin
              if (sts_i.emit_ok) state_d = sts_i.cnt_one ? ST_UNM : ST_RD;
            end else if (sts_i.tok_type == REQ_COMMA) begin
              state_d = ST_FIN;
            end else begin
              state_d = sts_i.cnt_one ? ST_FIN : ST_RDF;
            end
          end
          REQ_END: begin
            if (sts_i.emit_ok) state_d = sts_i.cnt_one ? ST_FIN : ST_RD;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_RDF: state_d = ST_CHKF;
      ST_CHKF: begin
        if (!sts_i.top_is_func || sts_i.emit_ok) state_d = ST_FIN;
      end
      ST_PUSH: begin
        if (!sts_i.full || sts_i.emit_ok) state_d = ST_FIN;
      end
      ST_UNM: begin
        if (sts_i.emit_ok) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.flush_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.emit = EMIT_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_tok = in_valid_i;
      end
      ST_START: begin
        if (sts_i.tok_type == REQ_OPERAND && sts_i.emit_ok) cmd_o.emit = EMIT_TOKEN;
      end
      ST_CHK: begin
        case (sts_i.tok_type)
          REQ_OPERATOR: begin
            if (sts_i.top_is_op && sts_i.pop_prec && sts_i.emit_ok) begin
              cmd_o.emit = EMIT_TOP;
              cmd_o.pop  = 1'b1;
            end
          end
          REQ_COMMA, REQ_RPAREN: begin
            if (!sts_i.top_is_lparen) begin
              if (sts_i.emit_ok) begin
                cmd_o.emit = EMIT_TOP;
                cmd_o.pop  = 1'b1;
              end
            end else if (sts_i.tok_type == REQ_RPAREN) begin
              cmd_o.pop = 1'b1;
            end
          end
          REQ_END: begin
            if (sts_i.emit_ok) begin
              cmd_o.emit = EMIT_TOP;
              cmd_o.pop  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_CHKF: begin
        if (sts_i.top_is_func && sts_i.emit_ok) begin
          cmd_o.emit = EMIT_TOP;
          cmd_o.pop  = 1'b1;
        end
      end
      ST_PUSH: begin
        if (!sts_i.full) begin
          cmd_o.push = 1'b1;
        end else if (sts_i.emit_ok) begin
          cmd_o.emit = EMIT_OVERFLOW;
        end
      end
      ST_UNM: begin
        if (sts_i.emit_ok) cmd_o.emit = EMIT_UNMATCHED;
      end
      ST_FIN: begin
        cmd_o.flush = sts_i.flush_ok;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/i2p_dpath.sv
// token registers, operator stack, pending result and output register
module i2p_dpath #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [2:0]                  req_type_i,
  input  logic [i2p_pkg::VAL_W-1:0]   token_value_i,
  input  i2p_pkg::cmd_t               cmd_i,
  output i2p_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [1:0]                  out_kind_o,
  output logic [i2p_pkg::VAL_W-1:0]   out_value_o,
  output logic [1:0]                  out_error_o,
  output logic                        out_last_o
);
  import i2p_pkg::*;

  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  req_e             tok_type_q;
  logic [VAL_W-1:0] tok_val_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cnt_m1;
  logic [ENT_W-1:0] top_ent;
  logic [ENT_W-1:0] push_ent;
  logic [3:0]       o1;
  logic             top_lparen, top_func;
  logic             out_free;

  logic             pend_valid_q, pend_valid_d;
  kind_e            pend_kind_q;
  logic [VAL_W-1:0] pend_val_q;
  err_e             pend_err_q;
  kind_e            new_kind;
  logic [VAL_W-1:0] new_val;
  err_e             new_err;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  kind_e            out_kind_q;
  logic [VAL_W-1:0] out_val_q;
  err_e             out_err_q;
  logic             out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      tok_type_q <= req_e'(req_type_i);
      tok_val_q  <= token_value_i;
    end
  end

  // saturated operator index
  assign o1 = (tok_val_q > VAL_W'(OP_MAX)) ? OP_MAX[3:0] : tok_val_q[3:0];

  always_comb begin
    case (tok_type_q)
      REQ_OPERATOR: push_ent = {1'b0, o1};
      REQ_FUNCTION: push_ent = ENT_FUNC_BASE | {3'b000, tok_val_q[1:0]};
      default:      push_ent = ENT_LPAREN;
    endcase
  end

  assign cnt_m1 = count_q - 1'b1;

  i2p_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (push_ent),
    .raddr_i (cnt_m1[IDX_W-1:0]),
    .rdata_o (top_ent)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_lparen = (top_ent == ENT_LPAREN);
  assign top_func   = (top_ent >= ENT_FUNC_BASE) && !top_lparen;

  // result built this cycle
  always_comb begin
    new_kind = KIND_OPERAND;
    new_val  = '0;
    new_err  = ERR_NONE;
    case (cmd_i.emit)
      EMIT_TOKEN: begin
        new_val = tok_val_q;
      end
      EMIT_TOP: begin
        if (top_lparen) begin
          new_kind = KIND_LPAREN;
          new_err  = ERR_LPAREN;
        end else if (top_func) begin
          new_kind = KIND_FUNCTION;
          new_val  = VAL_W'(top_ent - ENT_FUNC_BASE);
        end else begin
          new_kind = KIND_OPERATOR;
          new_val  = VAL_W'(top_ent);
        end
      end
      EMIT_UNMATCHED: begin
        new_err = ERR_RPAREN;
      end
      EMIT_OVERFLOW: begin
        new_err = ERR_OVERFLOW;
        case (tok_type_q)
          REQ_OPERATOR: begin
            new_kind = KIND_OPERATOR;
            new_val  = VAL_W'(o1);
          end
          REQ_FUNCTION: begin
            new_kind = KIND_FUNCTION;
            new_val  = VAL_W'(tok_val_q[1:0]);
          end
          default: new_kind = KIND_LPAREN;
        endcase
      end
      default: ;
    endcase
  end

  // one result is held back so that the last one of a token can be marked
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = pend_valid_q && ((cmd_i.emit != EMIT_NONE) || cmd_i.flush);

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.emit != EMIT_NONE) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EMIT_NONE) begin
      pend_kind_q <= new_kind;
      pend_val_q  <= new_val;
      pend_err_q  <= new_err;
    end
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_val_q  <= pend_val_q;
      out_err_q  <= pend_err_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign sts_o.tok_type      = tok_type_q;
  assign sts_o.cnt_zero      = (count_q == '0);
  assign sts_o.cnt_one       = (count_q == CNT_W'(1));
  assign sts_o.full          = (count_q == CNT_W'(STACK_DEPTH));
  assign sts_o.top_is_op     = (top_ent <= OP_MAX);
  assign sts_o.top_is_lparen = top_lparen;
  assign sts_o.top_is_func   = top_func;
  assign sts_o.pop_prec      = op_right(o1) ? (op_prec(o1) < op_prec(top_ent[3:0]))
                                            : (op_prec(o1) <= op_prec(top_ent[3:0]));
  assign sts_o.emit_ok       = !pend_valid_q || out_free;
  assign sts_o.flush_ok      = !pend_valid_q || out_free;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_val_q;
  assign out_error_o = out_err_q;
  assign out_last_o  = out_last_q;

endmodule

// File: sv/infix_to_postfix_converter.sv
// top level of the infix to postfix converter: stream ports, controller and datapath
// an operand passes from the token register to the held-back result and then to the output register
// a token is taken only in idle, then runs start and finish steps plus a read and a check per stack entry
//   examined, plus a push or an unmatched error step, plus any stall of the output
// a right paren also reads and checks the entry under the dropped paren for a function
// reset: asynchronous, active low; clears stack count, state machine, pending valid and output valid
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input tokens
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] token_value
  input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
  // postfix tokens
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] out_value, [17:16] out_error, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast    // out_last: final result of one input token
);
  import i2p_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [1:0]       out_kind;
  logic [VAL_W-1:0] out_value;
  logic [1:0]       out_error;

  // controller: walks one token through start, read, check, function check, push, unmatched and finish steps
  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: operator stack in ram, one held-back result, output register
  i2p_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (s_axis_tuser),
    .token_value_i (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_kind_o    (out_kind),
    .out_value_o   (out_value),
    .out_error_o   (out_error),
    .out_last_o    (m_axis_tlast)
  );

  // pack result fields, lowest first, zero filled to whole bytes
  assign m_axis_tdata = {6'd0, out_error, out_value};
  assign m_axis_tuser = out_kind;

endmodule
